[rtl/core/blr_pkg.sv]
`timescale 1ns / 1ps
// Package for the line rasterizer: configuration port sizes and register codes.
// No dependencies; used by blr_csr and the top level.
package blr_pkg;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int COLOUR_BITS   = 16;

   // Word index of each register (byte address divided by four).
   typedef enum logic {
      REG_DRAW_COLOUR = 1'b0,
      REG_UNUSED      = 1'b1
   } reg_index_type;

endpackage

[rtl/core/blr_csr.sv]
`timescale 1ns / 1ps
// Configuration register file: holds the draw colour behind an APB-style port.
// Depends on blr_pkg.
module blr_csr
   import blr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [COLOUR_BITS-1:0]   draw_colour
);

   logic [COLOUR_BITS-1:0] colour_ff;
   logic [COLOUR_BITS-1:0] colour_in;
   reg_index_type          reg_index;

   assign reg_index = reg_index_type'(paddr[2]);
   assign pready    = 1'b1;

   always_comb begin
      colour_in = colour_ff;
      if (psel && penable && pwrite && (reg_index == REG_DRAW_COLOUR)) begin
         colour_in = pwdata[COLOUR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= '0;
      end else begin
         colour_ff <= colour_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DRAW_COLOUR: prdata = {{(CSR_DATA_BITS-COLOUR_BITS){1'b0}}, colour_ff};
         default:         prdata = '0;
      endcase
   end

   assign draw_colour = colour_ff;

endmodule

[rtl/core/blr_walker.sv]
`timescale 1ns / 1ps
// Line walker: a small sequencer around one shared adder that sets up the
// deltas and decision term, then steps the decision term once per pixel.
// Self-contained; no package dependencies.
module blr_walker #(
   parameter int COORD_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] pixel_x,
   output logic [COORD_BITS-1:0] pixel_y,
   output logic                  last_pixel
);

   localparam int DW = COORD_BITS + 3;
   localparam int PAD = DW - COORD_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_DX, S_DY, S_ORIENT, S_INITD, S_DIFF, S_START, S_WALK
   } state_type;

   state_type state_ff, state_in;

   logic [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [COORD_BITS-1:0] x0_in, y0_in, x1_in, y1_in;
   logic signed [DW-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic signed [DW-1:0]  dscan_ff, dinc_ff, dscan_in, dinc_in;
   logic signed [DW-1:0]  d_ff, d_in, two_diff_ff, two_diff_in;
   logic                  xmajor_ff, xmajor_in;
   logic                  scan_neg_ff, scan_neg_in, inc_neg_ff, inc_neg_in;
   logic                  zero_ff, zero_in;
   logic [COORD_BITS-1:0] scan_ff, scan_in, inc_ff, inc_in;
   logic [COORD_BITS-1:0] scan_end_ff, scan_end_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                  out_last_ff, out_last_in;

   logic signed [DW-1:0]  add_a, add_b, add_sum;
   logic signed [DW-1:0]  two_dinc, abs_dx, abs_dy;
   logic                  out_free, x_major;
   logic [COORD_BITS-1:0] scan_next, inc_next, scan_one, inc_one;

   // The one shared adder; its operands follow the sequencer state.
   assign add_sum  = add_a + add_b;
   assign two_dinc = dinc_ff <<< 1;
   assign abs_dx   = dx_ff[DW-1] ? -dx_ff : dx_ff;
   assign abs_dy   = dy_ff[DW-1] ? -dy_ff : dy_ff;
   assign x_major  = abs_dx > abs_dy;
   assign out_free = !out_valid_ff || rsp_ready;

   assign scan_one  = scan_neg_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   assign inc_one   = inc_neg_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   assign scan_next = scan_ff + scan_one;
   assign inc_next  = (d_ff > 0) ? inc_ff + inc_one : inc_ff;

   always_comb begin
      unique case (state_ff)
         S_DX: begin
            add_a = $signed({{PAD{1'b0}}, x1_ff});
            add_b = -$signed({{PAD{1'b0}}, x0_ff});
         end
         S_DY: begin
            add_a = $signed({{PAD{1'b0}}, y1_ff});
            add_b = -$signed({{PAD{1'b0}}, y0_ff});
         end
         S_INITD: begin
            add_a = two_dinc;
            add_b = -dscan_ff;
         end
         S_DIFF: begin
            add_a = two_dinc;
            add_b = -(dscan_ff <<< 1);
         end
         S_WALK: begin
            add_a = d_ff;
            add_b = (d_ff > 0) ? two_diff_ff : two_dinc;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dscan_in     = dscan_ff;
      dinc_in      = dinc_ff;
      d_in         = d_ff;
      two_diff_in  = two_diff_ff;
      xmajor_in    = xmajor_ff;
      scan_neg_in  = scan_neg_ff;
      inc_neg_in   = inc_neg_ff;
      zero_in      = zero_ff;
      scan_in      = scan_ff;
      inc_in       = inc_ff;
      scan_end_in  = scan_end_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x0_in    = start_x;
               y0_in    = start_y;
               x1_in    = end_x;
               y1_in    = end_y;
               state_in = S_DX;
            end
         end
         S_DX: begin
            dx_in    = add_sum;
            state_in = S_DY;
         end
         S_DY: begin
            dy_in    = add_sum;
            state_in = S_ORIENT;
         end
         S_ORIENT: begin
            xmajor_in = x_major;
            zero_in   = (dx_ff == '0) && (dy_ff == '0);
            if (x_major) begin
               dscan_in    = abs_dx;
               dinc_in     = abs_dy;
               scan_neg_in = dx_ff[DW-1];
               inc_neg_in  = dy_ff[DW-1];
               scan_in     = x0_ff;
               inc_in      = y0_ff;
               scan_end_in = x1_ff;
            end else begin
               dscan_in    = abs_dy;
               dinc_in     = abs_dx;
               scan_neg_in = dy_ff[DW-1];
               inc_neg_in  = dx_ff[DW-1];
               scan_in     = y0_ff;
               inc_in      = x0_ff;
               scan_end_in = y1_ff;
            end
            state_in = S_INITD;
         end
         S_INITD: begin
            d_in     = add_sum;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            two_diff_in = add_sum;
            state_in    = S_START;
         end
         S_START: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = x0_ff;
               out_y_in     = y0_ff;
               out_last_in  = zero_ff;
               state_in     = zero_ff ? S_IDLE : S_WALK;
            end
         end
         S_WALK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (scan_next == scan_end_ff) begin
                  out_x_in    = x1_ff;
                  out_y_in    = y1_ff;
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  scan_in     = scan_next;
                  inc_in      = inc_next;
                  d_in        = add_sum;
                  out_x_in    = xmajor_ff ? scan_next : inc_next;
                  out_y_in    = xmajor_ff ? inc_next : scan_next;
                  out_last_in = 1'b0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dscan_ff    <= dscan_in;
      dinc_ff     <= dinc_in;
      d_ff        <= d_in;
      two_diff_ff <= two_diff_in;
      xmajor_ff   <= xmajor_in;
      scan_neg_ff <= scan_neg_in;
      inc_neg_ff  <= inc_neg_in;
      zero_ff     <= zero_in;
      scan_ff     <= scan_in;
      inc_ff      <= inc_in;
      scan_end_ff <= scan_end_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = out_valid_ff;
   assign pixel_x    = out_x_ff;
   assign pixel_y    = out_y_ff;
   assign last_pixel = out_last_ff;

endmodule

[rtl/core/bresenham_line_rasterizer_top.sv]
`timescale 1ns / 1ps
// Top level of the Bresenham line rasterizer: configuration registers and the
// line walker. Depends on blr_pkg, blr_csr and blr_walker.

// Each request beat carries the two endpoints of a line; the block answers with
// one response beat per pixel, in walk order from the start point to the end
// point, every beat tagged with the draw colour and the end point flagged by
// last_pixel. A line of major length L gives L + 1 beats, and a zero-length
// line gives a single beat, the start point, already flagged as last. A line is
// accepted in S_IDLE, passes through the setup states S_DX, S_DY, S_ORIENT,
// S_INITD and S_DIFF, and is then emitted from S_START and S_WALK, where a
// response stall holds the walk. The walk is paced by a single shared adder that
// first forms the deltas and the decision term and then steps that term once
// per pixel. The request side is ready only while no line is in flight, but it
// already takes the next line while the final pixel still waits in the output
// register. The draw colour lives at byte address 0 of the APB-style port. It
// is attached to the pixels straight from the register, so it must be changed
// only while no line is in progress and no pixel beat is waiting.
module bresenham_line_rasterizer_top
   import blr_pkg::*;
#(
   parameter int COORD_BITS = 6
) (
   input  logic                     clock,
   input  logic                     reset,

   // Configuration port; pready is tied high.
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,

   // Request channel: one beat per line.
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_BITS-1:0]    req_start_x,
   input  logic [COORD_BITS-1:0]    req_start_y,
   input  logic [COORD_BITS-1:0]    req_end_x,
   input  logic [COORD_BITS-1:0]    req_end_y,

   // Response channel: one beat per pixel.
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_pixel_x,
   output logic [COORD_BITS-1:0]    rsp_pixel_y,
   output logic [COLOUR_BITS-1:0]   rsp_pixel_colour,
   output logic                     rsp_last_pixel
);

   logic [COLOUR_BITS-1:0] draw_colour;

   blr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .draw_colour (draw_colour)
   );

   blr_walker #(
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .pixel_x    (rsp_pixel_x),
      .pixel_y    (rsp_pixel_y),
      .last_pixel (rsp_last_pixel)
   );

   // The colour is to be changed only between lines, which the block does not enforce;
   // it is attached straight from the register rather than carried through the walker.
   assign rsp_pixel_colour = draw_colour;

endmodule
